FILE: hdl/lras_pkg.sv
// shared types and constants of the line rasteriser
package lras_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int COUNT_BITS = 16;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_len;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [ERR_BITS-1:0]   t_err;
    typedef logic        [COUNT_BITS-1:0] t_count;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef struct packed {
        logic moves;
        logic neg;
    } t_dir;

    typedef struct packed {
        t_op    op;
        logic   count_only;
        t_coord begin_x;
        t_coord begin_y;
        t_dir   dir_x;
        t_dir   dir_y;
        logic   swapped;
        t_len   major;
        t_err   err_init;
        t_err   err_diag;
        t_err   err_axial;
    } t_cmd;

endpackage

FILE: hdl/lras_front.sv
// front end: accepts transactions and works out the segment set-up
module lras_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_operation,
    input  lras_pkg::t_coord i_start_x,
    input  lras_pkg::t_coord i_start_y,
    input  lras_pkg::t_coord i_end_x,
    input  lras_pkg::t_coord i_end_y,
    input  logic            i_count_only,
    input  logic            i_full,
    output logic            o_push,
    output lras_pkg::t_cmd  o_cmd
);
    import lras_pkg::*;

    logic   r_valid;
    t_op    r_op;
    logic   r_count_only;
    t_coord r_bx;
    t_coord r_by;
    t_diff  r_dx;
    t_diff  r_ndx;
    t_diff  r_dy;
    t_diff  r_ndy;

    logic   ready;
    logic   accept;
    t_len   abs_x;
    t_len   abs_y;
    t_len   major;
    t_len   minor;
    logic   swapped;
    t_err   minor_twice;
    t_err   major_once;
    t_err   major_twice;

    assign ready   = !r_valid || !i_full;
    assign o_stall = !ready;
    assign accept  = i_valid && ready;
    assign o_push  = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= t_op'(i_operation);
            r_count_only <= i_count_only;
            r_bx         <= i_start_x;
            r_by         <= i_start_y;
            r_dx         <= t_diff'(i_end_x) - t_diff'(i_start_x);
            r_ndx        <= t_diff'(i_start_x) - t_diff'(i_end_x);
            r_dy         <= t_diff'(i_end_y) - t_diff'(i_start_y);
            r_ndy        <= t_diff'(i_start_y) - t_diff'(i_end_y);
        end
    end

    always_comb begin
        abs_x       = r_dx[DIFF_BITS-1] ? r_ndx[COORD_BITS-1:0] : r_dx[COORD_BITS-1:0];
        abs_y       = r_dy[DIFF_BITS-1] ? r_ndy[COORD_BITS-1:0] : r_dy[COORD_BITS-1:0];
        swapped     = abs_y > abs_x;
        major       = swapped ? abs_y : abs_x;
        minor       = swapped ? abs_x : abs_y;
        minor_twice = t_err'({1'b0, minor, 1'b0});
        major_once  = t_err'({1'b0, major});
        major_twice = t_err'({1'b0, major, 1'b0});

        o_cmd.op         = r_op;
        o_cmd.count_only = r_count_only;
        o_cmd.begin_x    = r_bx;
        o_cmd.begin_y    = r_by;
        o_cmd.dir_x      = '{moves: (r_dx != '0), neg: r_dx[DIFF_BITS-1]};
        o_cmd.dir_y      = '{moves: (r_dy != '0), neg: r_dy[DIFF_BITS-1]};
        o_cmd.swapped    = swapped;
        o_cmd.major      = major;
        o_cmd.err_init   = minor_twice - major_once;
        o_cmd.err_diag   = minor_twice - major_twice;
        o_cmd.err_axial  = minor_twice;
    end

endmodule

FILE: hdl/lras_fifo.sv
// short command queue between front end and stepper
module lras_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lras_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output lras_pkg::t_cmd o_cmd
);
    import lras_pkg::*;

    t_cmd                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full     = (r_cnt == QCNT_BITS'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_cmd      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_BITS'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_BITS'(1);
            end
        end
    end

endmodule

FILE: hdl/lras_back.sv
// stepper: walks the segment and holds the result register
module lras_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  lras_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output lras_pkg::t_coord o_pixel_x,
    output lras_pkg::t_coord o_pixel_y,
    output logic             o_plot,
    output lras_pkg::t_count o_diagonal_steps,
    output logic             o_last
);
    import lras_pkg::*;

    logic   r_active;
    t_coord r_x;
    t_coord r_y;
    t_err   r_err;
    t_len   r_rem;
    t_err   r_err_diag;
    t_err   r_err_axial;
    t_dir   r_dir_x;
    t_dir   r_dir_y;
    logic   r_swapped;
    logic   r_counting;
    t_count r_count;

    logic   r_out_valid;
    t_coord r_px;
    t_coord r_py;
    logic   r_plot;
    t_count r_dsteps;
    logic   r_last;

    logic   n_active;
    t_coord n_x;
    t_coord n_y;
    t_err   n_err;
    t_len   n_rem;
    t_count n_count;

    logic   out_free;
    logic   is_start;
    logic   emit;
    logic   diag;
    t_coord x_moved;
    t_coord y_moved;

    function automatic t_coord step_coord(input t_coord c, input t_dir d);
        t_coord r;
        if (!d.moves) begin
            r = c;
        end else if (d.neg) begin
            r = c - t_coord'(1);
        end else begin
            r = c + t_coord'(1);
        end
        return r;
    endfunction

    assign out_free = !r_out_valid || !i_stall;
    assign is_start = (i_cmd.op == OP_START);
    assign o_pop    = i_q_valid && (is_start || out_free);
    assign emit     = o_pop && !is_start && r_active;
    assign diag     = r_err > t_err'(0);
    assign x_moved  = step_coord(r_x, r_dir_x);
    assign y_moved  = step_coord(r_y, r_dir_y);

    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_err    = r_err;
        n_rem    = r_rem;
        n_count  = r_count;
        if (emit && r_rem != '0) begin
            if (r_swapped) begin
                n_x = diag ? x_moved : r_x;
                n_y = y_moved;
            end else begin
                n_x = x_moved;
                n_y = diag ? y_moved : r_y;
            end
            n_err = r_err + (diag ? r_err_diag : r_err_axial);
            n_rem = r_rem - t_len'(1);
            if (r_counting && diag) begin
                n_count = r_count + t_count'(1);
            end
            if (n_rem == '0) begin
                n_active = 1'b0;
            end
        end else if (emit) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_err       <= '0;
            r_rem       <= '0;
            r_err_diag  <= '0;
            r_err_axial <= '0;
            r_dir_x     <= '0;
            r_dir_y     <= '0;
            r_swapped   <= 1'b0;
            r_counting  <= 1'b0;
            r_count     <= '0;
        end else if (o_pop && is_start) begin
            r_active    <= 1'b1;
            r_x         <= i_cmd.begin_x;
            r_y         <= i_cmd.begin_y;
            r_err       <= i_cmd.err_init;
            r_rem       <= i_cmd.major;
            r_err_diag  <= i_cmd.err_diag;
            r_err_axial <= i_cmd.err_axial;
            r_dir_x     <= i_cmd.dir_x;
            r_dir_y     <= i_cmd.dir_y;
            r_swapped   <= i_cmd.swapped;
            r_counting  <= i_cmd.count_only;
            r_count     <= '0;
        end else begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_err    <= n_err;
            r_rem    <= n_rem;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_px     <= r_x;
            r_py     <= r_y;
            r_plot   <= !r_counting;
            r_dsteps <= (r_rem == '0) ? '0 : n_count;
            r_last   <= (r_rem == '0) || (r_rem == t_len'(1));
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pixel_x        = r_px;
    assign o_pixel_y        = r_py;
    assign o_plot           = r_plot;
    assign o_diagonal_steps = r_dsteps;
    assign o_last           = r_last;

endmodule

FILE: hdl/line_rasterizer_unit.sv
// top level of the line rasteriser
//
// input channel (i_valid / o_stall) takes start and step transactions; a start
// loads both endpoints and the count-only flag and gives no result, a step
// gives one pixel result while a segment is live and nothing otherwise
// output channel (o_valid / i_stall) carries pixel, plot flag, diagonal count
// and last marker; a segment of major length L gives L results, zero length one
// a step passes the front register and the queue into the result register
// throughput: one transaction per cycle unless stalled, set by the single
// error-term add and the coordinate increment of the stepper each cycle
// the front end registers the deltas and builds the set-up, a four-entry queue
// decouples it from the stepper, whose result register is the output stage
// a receiver stall holds the result register, the stepper still drains starts,
// the queue fills and o_stall rises once the queue and front register are full
// synchronous reset empties the queue and pipeline and drops any live segment
module line_rasterizer_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  lras_pkg::t_coord i_start_x,
    input  lras_pkg::t_coord i_start_y,
    input  lras_pkg::t_coord i_end_x,
    input  lras_pkg::t_coord i_end_y,
    input  logic             i_count_only,
    output logic             o_valid,
    input  logic             i_stall,
    output lras_pkg::t_coord o_pixel_x,
    output lras_pkg::t_coord o_pixel_y,
    output logic             o_plot,
    output lras_pkg::t_count o_diagonal_steps,
    output logic             o_last
);
    import lras_pkg::*;

    logic q_push;
    logic q_full;
    logic q_nonempty;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd head_cmd;

    lras_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_count_only (i_count_only),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    lras_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (front_cmd),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_cmd      (head_cmd)
    );

    lras_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_nonempty),
        .i_cmd            (head_cmd),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_plot           (o_plot),
        .o_diagonal_steps (o_diagonal_steps),
        .o_last           (o_last)
    );

endmodule

FILE: hdl/lras_checker.sv
// port-level checks of the line rasteriser and their binding
module lras_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_operation,
    input lras_pkg::t_coord i_start_x,
    input lras_pkg::t_coord i_start_y,
    input lras_pkg::t_coord i_end_x,
    input lras_pkg::t_coord i_end_y,
    input logic             i_count_only,
    input logic             o_valid,
    input logic             i_stall,
    input lras_pkg::t_coord o_pixel_x,
    input lras_pkg::t_coord o_pixel_y,
    input logic             o_plot,
    input lras_pkg::t_count o_diagonal_steps,
    input logic             o_last
);

    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_plot) && $stable(o_diagonal_steps) && $stable(o_last)
    ) else $error("result changed while stalled");

    a_reset_empty: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall
    ) else $error("result or stall present after reset");

    a_plot_no_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_plot |-> o_diagonal_steps == '0
    ) else $error("diagonal count reported while plotting");

endmodule

bind line_rasterizer_unit lras_checker u_lras_checker (.*);

FILE: sim/tb.sv
// self-checking testbench of the line rasteriser: directed rows, random segments, stepper predictor
`timescale 1ns / 1ps

module tb;
    import lras_pkg::*;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   plot;
        t_count diag;
        logic   last;
    } t_pixel;

    typedef struct {
        t_op    op;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        logic   co;
        bit     typed;
        t_pixel want;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    logic   i_operation = OP_START;
    t_coord i_start_x = '0;
    t_coord i_start_y = '0;
    t_coord i_end_x = '0;
    t_coord i_end_y = '0;
    logic   i_count_only = 1'b0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic   o_plot;
    t_count o_diagonal_steps;
    logic   o_last;

    line_rasterizer_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    // stepper state of the predictor
    logic                 seg_live = 1'b0;
    t_coord               cur_x = '0;
    t_coord               cur_y = '0;
    t_err                 err_acc = '0;
    logic [DIFF_BITS-1:0] pix_left = '0;
    t_err                 maj2 = '0;
    t_err                 min2 = '0;
    t_dir                 dir_x = '0;
    t_dir                 dir_y = '0;
    logic                 steep = 1'b0;
    logic                 counting = 1'b0;
    t_count               diag_cnt = '0;

    t_pixel pixel_q[$];
    t_pixel pix_exp;
    t_row   dir_rows[$];
    int     n_fail = 0;
    int     n_items = 0;
    int     burst_left = 0;
    int     rx_left = 0;
    int     rx_mode = 0;

    function automatic t_coord nudge(input t_coord c, input t_dir d);
        if (!d.moves)
            return c;
        return d.neg ? t_coord'(c - t_coord'(1)) : t_coord'(c + t_coord'(1));
    endfunction

    function automatic bit raster_predict(input t_row row, output t_pixel px);
        t_diff                dx;
        t_diff                dy;
        logic [DIFF_BITS-1:0] adx;
        logic [DIFF_BITS-1:0] ady;
        logic [DIFF_BITS-1:0] mj;
        logic [DIFF_BITS-1:0] mn;
        px = '0;
        if (row.op == OP_START) begin
            dx = t_diff'(row.ex) - t_diff'(row.sx);
            dy = t_diff'(row.ey) - t_diff'(row.sy);
            dir_x.moves = (dx != 0);
            dir_x.neg = (dx < 0);
            dir_y.moves = (dy != 0);
            dir_y.neg = (dy < 0);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            steep = (ady > adx);
            mj = steep ? ady : adx;
            mn = steep ? adx : ady;
            maj2 = t_err'({mj, 1'b0});
            min2 = t_err'({mn, 1'b0});
            err_acc = min2 - t_err'(mj);
            pix_left = mj;
            cur_x = row.sx;
            cur_y = row.sy;
            counting = row.co;
            diag_cnt = '0;
            seg_live = 1'b1;
            return 1'b0;
        end
        if (!seg_live)
            return 1'b0;
        px.x = cur_x;
        px.y = cur_y;
        px.plot = !counting;
        if (pix_left == 0) begin
            px.last = 1'b1;
            seg_live = 1'b0;
            return 1'b1;
        end
        if (err_acc > 0) begin
            if (steep)
                cur_x = nudge(cur_x, dir_x);
            else
                cur_y = nudge(cur_y, dir_y);
            err_acc = err_acc - maj2;
            if (counting)
                diag_cnt = diag_cnt + 1'b1;
        end
        if (steep)
            cur_y = nudge(cur_y, dir_y);
        else
            cur_x = nudge(cur_x, dir_x);
        err_acc = err_acc + min2;
        pix_left = pix_left - 1'b1;
        px.diag = counting ? diag_cnt : '0;
        px.last = (pix_left == 0);
        if (pix_left == 0)
            seg_live = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_row mk(input t_op op, input int sx = 0, input int sy = 0,
                                input int ex = 0, input int ey = 0, input logic co = 1'b0);
        t_row r;
        r.op = op;
        r.typed = 1'b0;
        r.want = '0;
        if (op == OP_STEP) begin
            // coordinates are ignored on a step, so toggle them freely
            r.sx = t_coord'($urandom);
            r.sy = t_coord'($urandom);
            r.ex = t_coord'($urandom);
            r.ey = t_coord'($urandom);
            r.co = 1'($urandom_range(0, 1));
        end else begin
            r.sx = t_coord'(sx);
            r.sy = t_coord'(sy);
            r.ex = t_coord'(ex);
            r.ey = t_coord'(ey);
            r.co = co;
        end
        return r;
    endfunction

    task automatic add_start(input int sx, input int sy, input int ex, input int ey,
                             input logic co);
        dir_rows.push_back(mk(OP_START, sx, sy, ex, ey, co));
    endtask

    task automatic add_step(input bit typed = 1'b0, input int wx = 0, input int wy = 0,
                            input logic wp = 1'b0, input int wd = 0, input logic wl = 1'b0);
        t_row r;
        r = mk(OP_STEP);
        r.typed = typed;
        r.want = '{t_coord'(wx), t_coord'(wy), wp, t_count'(wd), wl};
        dir_rows.push_back(r);
    endtask

    task automatic send_item(input t_row row);
        t_pixel got;
        bit     has;
        int     g;
        g = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 30);
            g = $urandom_range(1, 7);
        end
        burst_left--;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= row.op;
        i_start_x <= row.sx;
        i_start_y <= row.sy;
        i_end_x <= row.ex;
        i_end_y <= row.ey;
        i_count_only <= row.co;
        do @(posedge i_clk); while (o_stall);
        has = raster_predict(row, got);
        if (has)
            pixel_q.push_back(row.typed ? row.want : got);
        n_items++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic field_check(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // receiver stall pattern: free runs, light random stalls, heavy periodic stalls
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
                i_stall <= (rx_left % 4 != 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected transaction: x %0d y %0d", o_pixel_x, o_pixel_y);
                n_fail++;
            end else begin
                pix_exp = pixel_q.pop_front();
                field_check("pixel_x", int'(pix_exp.x), int'(o_pixel_x));
                field_check("pixel_y", int'(pix_exp.y), int'(o_pixel_y));
                field_check("plot", int'(pix_exp.plot), int'(o_plot));
                field_check("diagonal_steps", int'(pix_exp.diag), int'(o_diagonal_steps));
                field_check("last", int'(pix_exp.last), int'(o_last));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int r;
        int len;
        int bx;
        int by;
        int ex;
        int ey;
        int ddx;
        int ddy;
        int mj;
        int nsteps;
        int next_drain;

        // step while idle, zero-length segments
        add_step();
        add_start(0, 0, 0, 0, 1'b0);
        add_step(1'b1, 0, 0, 1'b1, 0, 1'b1);
        add_step();
        add_start(0, 0, 0, 0, 1'b1);
        add_step(1'b1, 0, 0, 1'b0, 0, 1'b1);
        // full-range diagonals, the second abandoning the first
        add_start(-32768, 32767, 32767, -32768, 1'b1);
        add_step(1'b1, -32768, 32767, 1'b0, 1, 1'b0);
        add_step();
        add_start(32767, -32768, -32768, 32767, 1'b0);
        add_step(1'b1, 32767, -32768, 1'b1, 0, 1'b0);
        add_step();
        // steep octant
        add_start(5, 5, 7, 12, 1'b0);
        repeat (3) add_step();
        // shallow, both signs negative, counted to the end
        add_start(10, -3, 7, -4, 1'b1);
        repeat (4) add_step();
        // vertical at the left edge
        add_start(-32768, 0, -32768, -4, 1'b0);
        repeat (2) add_step();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        drain();

        next_drain = n_items + 300;
        while (n_items < 900) begin
            if (n_items >= next_drain) begin
                drain();
                next_drain += 300;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_item(mk(OP_STEP));
                continue;
            end
            if ($urandom_range(0, 9) < 4) begin
                bx = $urandom_range(0, 65535) - 32768;
                by = $urandom_range(0, 65535) - 32768;
            end else begin
                bx = $urandom_range(0, 80) - 40;
                by = $urandom_range(0, 80) - 40;
            end
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 12);
            ddx = $urandom_range(0, 2 * len) - len;
            ddy = $urandom_range(0, 2 * len) - len;
            ex = bx + ddx;
            ey = by + ddy;
            if (ex > 32767 || ex < -32768)
                ex = bx - ddx;
            if (ey > 32767 || ey < -32768)
                ey = by - ddy;
            if ($urandom_range(0, 19) == 0) begin
                ex = $urandom_range(0, 65535) - 32768;
                ey = $urandom_range(0, 65535) - 32768;
            end
            mj = (ex > bx) ? ex - bx : bx - ex;
            if (((ey > by) ? ey - by : by - ey) > mj)
                mj = (ey > by) ? ey - by : by - ey;
            nsteps = mj + 1;
            r = $urandom_range(0, 19);
            if (r < 3)
                nsteps = $urandom_range(0, mj);
            else if (r < 5)
                nsteps += $urandom_range(1, 3);
            if (nsteps > 40)
                nsteps = $urandom_range(1, 40);
            send_item(mk(OP_START, bx, by, ex, ey, 1'($urandom_range(0, 1))));
            repeat (nsteps) send_item(mk(OP_STEP));
        end

        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_fail == 0 && pixel_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lras_pkg.sv
hdl/lras_front.sv
hdl/lras_fifo.sv
hdl/lras_back.sv
hdl/line_rasterizer_unit.sv
hdl/lras_checker.sv
sim/tb.sv
